// ===== rtl/vna_pkg.sv =====
// Shared types and constants for the vertex normal accumulator.
`default_nettype none

package vna_pkg;

  localparam int DEF_MAX_VERTICES = 1024;
  localparam int DEF_POS_BITS     = 16;

  localparam int VCOUNT_W   = 11;
  localparam int ACC_W      = 48;
  localparam int START_W    = 32;
  localparam int UNIT_W     = 16;
  localparam int ADDR_MAX_W = 16;
  localparam int POS_MAX_W  = 20;

  localparam logic [ACC_W-1:0]  ACC_MAX  = 48'h7FFF_FFFF_FFFF;
  localparam logic [ACC_W-1:0]  ACC_MIN  = 48'h8000_0000_0000;
  localparam logic [UNIT_W-1:0] UNIT_ONE = 16'd16384;

  localparam logic [1:0] STATUS_OK          = 2'd0;
  localparam logic [1:0] STATUS_BAD_INDEX   = 2'd1;
  localparam logic [1:0] STATUS_NO_TRIANGLE = 2'd2;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_TRI   = 2'd1,
    KIND_READ  = 2'd2,
    KIND_BEGIN = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0]                kind;
    logic [9:0]                vertex_index;
    logic signed [15:0]        pos_x;
    logic signed [15:0]        pos_y;
    logic signed [15:0]        pos_z;
    logic signed [START_W-1:0] start_normal_x;
    logic signed [START_W-1:0] start_normal_y;
    logic signed [START_W-1:0] start_normal_z;
    logic [11:0]               corner_a;
    logic [11:0]               corner_b;
    logic [11:0]               corner_c;
  } item_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [UNIT_W-1:0] unit_x;
    logic signed [UNIT_W-1:0] unit_y;
    logic signed [UNIT_W-1:0] unit_z;
  } result_t;

  typedef struct packed {
    kind_t                     kind;
    logic                      slot_ok;
    logic                      tri_ok;
    logic [ADDR_MAX_W-1:0]     slot;
    logic [ADDR_MAX_W-1:0]     ca;
    logic [ADDR_MAX_W-1:0]     cb;
    logic [ADDR_MAX_W-1:0]     cc;
    logic [POS_MAX_W-1:0]      px;
    logic [POS_MAX_W-1:0]      py;
    logic [POS_MAX_W-1:0]      pz;
    logic signed [START_W-1:0] nx;
    logic signed [START_W-1:0] ny;
    logic signed [START_W-1:0] nz;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/vna_front.sv =====
// Front end: vertex count register, item intake and index classification.
`default_nettype none

module vna_front #(
  parameter int MAX_VERTICES = 1024,
  parameter int POS_BITS     = 16
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         cfg_valid,
  output logic                        cfg_ready,
  input  wire [10:0]                  cfg_data,
  input  wire                         item_valid,
  output logic                        item_ready,
  input  vna_pkg::item_t              item,
  input  wire                         full,
  output logic                        push,
  output vna_pkg::cmd_t               cmd
);
  import vna_pkg::*;

  localparam int SH = POS_MAX_W - POS_BITS;

  logic [VCOUNT_W-1:0] vcount;
  logic                ok_a;
  logic                ok_b;
  logic                ok_c;

  function automatic logic [POS_MAX_W-1:0] pos_fit(input logic signed [15:0] p);
    logic signed [POS_MAX_W-1:0] w;
    w = POS_MAX_W'(p);
    w = (w <<< SH) >>> SH;
    return w;
  endfunction

  function automatic logic corner_ok(input logic [11:0] c, input logic [VCOUNT_W-1:0] vc);
    return ({20'd0, c} < {21'd0, vc}) && ({20'd0, c} < 32'(MAX_VERTICES));
  endfunction

  assign cfg_ready  = 1'b1;
  assign item_ready = !full;
  assign push       = item_valid && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      vcount <= '0;
    end else if (cfg_valid) begin
      vcount <= cfg_data;
    end
  end

  always_comb begin
    ok_a        = corner_ok(item.corner_a, vcount);
    ok_b        = corner_ok(item.corner_b, vcount);
    ok_c        = corner_ok(item.corner_c, vcount);
    cmd.kind    = kind_t'(item.kind);
    cmd.slot_ok = ({22'd0, item.vertex_index} < 32'(MAX_VERTICES));
    cmd.tri_ok  = ok_a && ok_b && ok_c;
    cmd.slot    = {6'd0, item.vertex_index};
    cmd.ca      = {4'd0, item.corner_a};
    cmd.cb      = {4'd0, item.corner_b};
    cmd.cc      = {4'd0, item.corner_c};
    cmd.px      = pos_fit(item.pos_x);
    cmd.py      = pos_fit(item.pos_y);
    cmd.pz      = pos_fit(item.pos_z);
    cmd.nx      = item.start_normal_x;
    cmd.ny      = item.start_normal_y;
    cmd.nz      = item.start_normal_z;
  end

endmodule

`default_nettype wire

// ===== rtl/vna_fifo.sv =====
// Command queue between the front end and the back end.
`default_nettype none

module vna_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              push,
  input  wire [WIDTH-1:0]  din,
  input  wire              pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty,
  output logic             full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW:0]      wr_ptr;
  logic [PW:0]      rd_ptr;

  assign empty = (wr_ptr == rd_ptr);
  assign full  = (wr_ptr[PW] != rd_ptr[PW]) && (wr_ptr[PW-1:0] == rd_ptr[PW-1:0]);
  assign dout  = mem[rd_ptr[PW-1:0]];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr[PW-1:0]] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/vna_norm.sv =====
// Iterative normalizer: scales a 48-bit vector to a Q1.14 unit vector.
`default_nettype none

module vna_norm (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             start,
  input  wire signed [vna_pkg::ACC_W-1:0] vec_x,
  input  wire signed [vna_pkg::ACC_W-1:0] vec_y,
  input  wire signed [vna_pkg::ACC_W-1:0] vec_z,
  output logic                            done,
  output logic [vna_pkg::UNIT_W-1:0]      unit_x,
  output logic [vna_pkg::UNIT_W-1:0]      unit_y,
  output logic [vna_pkg::UNIT_W-1:0]      unit_z
);
  import vna_pkg::*;

  typedef enum logic [2:0] {
    N_IDLE, N_MAX, N_SHIFT, N_SQ, N_ROOT, N_DINIT, N_DIV, N_DONE
  } nstate_t;

  nstate_t           state;
  logic [ACC_W-1:0]  mag [3];
  logic [2:0]        neg;
  logic [ACC_W-1:0]  m;
  logic [3:0]        cnt;
  logic [1:0]        lane;
  logic [59:0]       sq;
  logic [63:0]       sum;
  logic [63:0]       root;
  logic [63:0]       bitv;
  logic [31:0]       rem;
  logic [15:0]       dsh;
  logic [15:0]       quo;

  logic [ACC_W-1:0]  mx;
  logic [ACC_W-1:0]  sq_sel;
  logic [ACC_W-1:0]  dv_sel;
  logic              neg_sel;
  logic [31:0]       n32;
  logic [63:0]       trial_root;
  logic [44:0]       d_init;
  logic [32:0]       trial;
  logic [32:0]       diff;
  logic              ge;
  logic [15:0]       q_next;
  logic [15:0]       u;
  logic [15:0]       unit_val;

  always_comb begin
    mx = (mag[0] > mag[1]) ? mag[0] : mag[1];
    mx = (mx > mag[2]) ? mx : mag[2];
    case (cnt[1:0])
      2'd0:    sq_sel = mag[0];
      2'd1:    sq_sel = mag[1];
      default: sq_sel = mag[2];
    endcase
    case (lane)
      2'd0: begin
        dv_sel  = mag[0];
        neg_sel = neg[0];
      end
      2'd1: begin
        dv_sel  = mag[1];
        neg_sel = neg[1];
      end
      default: begin
        dv_sel  = mag[2];
        neg_sel = neg[2];
      end
    endcase
    n32        = root[31:0];
    trial_root = root + bitv;
    d_init     = {dv_sel[29:0], 14'd0} + 45'(n32[31:1]);
    trial      = {rem, dsh[15]};
    diff       = trial - {1'b0, n32};
    ge         = (trial >= {1'b0, n32});
    q_next     = {quo[14:0], ge};
    u          = (q_next > UNIT_ONE) ? UNIT_ONE : q_next;
    unit_val   = neg_sel ? 16'(16'd0 - u) : u;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
      done  <= 1'b0;
    end else begin
      unique case (state)
        N_IDLE: begin
          done <= 1'b0;
          if (start) begin
            mag[0] <= vec_x[ACC_W-1] ? ACC_W'(-vec_x) : ACC_W'(vec_x);
            mag[1] <= vec_y[ACC_W-1] ? ACC_W'(-vec_y) : ACC_W'(vec_y);
            mag[2] <= vec_z[ACC_W-1] ? ACC_W'(-vec_z) : ACC_W'(vec_z);
            neg    <= {vec_z[ACC_W-1], vec_y[ACC_W-1], vec_x[ACC_W-1]};
            state  <= N_MAX;
          end
        end
        N_MAX: begin
          m <= mx;
          if (mx == '0) begin
            unit_x <= '0;
            unit_y <= '0;
            unit_z <= '0;
            state  <= N_DONE;
          end else begin
            state <= N_SHIFT;
          end
        end
        N_SHIFT: begin
          if (m[ACC_W-1:30] != '0) begin
            m <= m >> 1;
            for (int i = 0; i < 3; i++) begin
              mag[i] <= mag[i] >> 1;
            end
          end else if (!m[29]) begin
            m <= m << 1;
            for (int i = 0; i < 3; i++) begin
              mag[i] <= mag[i] << 1;
            end
          end else begin
            cnt   <= '0;
            sum   <= '0;
            state <= N_SQ;
          end
        end
        N_SQ: begin
          if (cnt != 4'd3) begin
            sq <= sq_sel[29:0] * sq_sel[29:0];
          end
          if (cnt != 4'd0) begin
            sum <= sum + 64'(sq);
          end
          if (cnt == 4'd3) begin
            root  <= '0;
            bitv  <= 64'd1 << 62;
            state <= N_ROOT;
          end
          cnt <= cnt + 4'd1;
        end
        N_ROOT: begin
          if (sum >= trial_root) begin
            sum  <= sum - trial_root;
            root <= (root >> 1) + bitv;
          end else begin
            root <= root >> 1;
          end
          bitv <= bitv >> 2;
          if (bitv[0]) begin
            lane  <= '0;
            state <= N_DINIT;
          end
        end
        N_DINIT: begin
          rem   <= 32'(d_init[44:16]);
          dsh   <= d_init[15:0];
          quo   <= '0;
          cnt   <= 4'd15;
          state <= N_DIV;
        end
        N_DIV: begin
          rem <= ge ? diff[31:0] : trial[31:0];
          dsh <= dsh << 1;
          quo <= q_next;
          cnt <= cnt - 4'd1;
          if (cnt == 4'd0) begin
            case (lane)
              2'd0:    unit_x <= unit_val;
              2'd1:    unit_y <= unit_val;
              default: unit_z <= unit_val;
            endcase
            if (lane == 2'd2) begin
              state <= N_DONE;
            end else begin
              lane  <= lane + 2'd1;
              state <= N_DINIT;
            end
          end
        end
        N_DONE: begin
          done  <= 1'b1;
          state <= N_IDLE;
        end
        default: state <= N_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/vna_back.sv =====
// Back end: vertex and accumulator memories, triangle and read sequencer.
`default_nettype none

module vna_back #(
  parameter int MAX_VERTICES = 1024,
  parameter int POS_BITS     = 16
) (
  input  wire                clk,
  input  wire                rst,
  input  vna_pkg::cmd_t      cmd,
  input  wire                empty,
  output logic               pop,
  output logic               result_valid,
  input  wire                result_ready,
  output vna_pkg::result_t   result
);
  import vna_pkg::*;

  localparam int AW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int PW  = POS_BITS;
  localparam int EW  = PW + 1;
  localparam int PRW = 2 * EW;
  localparam int FW  = PRW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_P0, S_P1, S_P2, S_EDGE, S_MUL, S_ARD, S_AWR,
    S_RRD, S_RSTART, S_RWAIT, S_OUT
  } state_t;

  logic [3*PW-1:0]        pos_mem [MAX_VERTICES];
  logic signed [ACC_W-1:0] acc_x_mem [MAX_VERTICES];
  logic signed [ACC_W-1:0] acc_y_mem [MAX_VERTICES];
  logic signed [ACC_W-1:0] acc_z_mem [MAX_VERTICES];

  state_t                  state;
  cmd_t                    cur;
  logic                    bad;
  logic                    tri_seen;
  logic [3*PW-1:0]         pa;
  logic [3*PW-1:0]         pb;
  logic signed [EW-1:0]    e1x, e1y, e1z, e2x, e2y, e2z;
  logic signed [PRW-1:0]   prod;
  logic signed [FW-1:0]    fx, fy, fz;
  logic [2:0]              mcnt;
  logic [1:0]              cj;
  result_t                 res;

  logic                    pos_we;
  logic [AW-1:0]           pos_wa;
  logic [3*PW-1:0]         pos_wd;
  logic [AW-1:0]           pos_ra;
  logic [3*PW-1:0]         pos_q;
  logic                    acc_we;
  logic [AW-1:0]           acc_wa;
  logic signed [ACC_W-1:0] acc_wd_x, acc_wd_y, acc_wd_z;
  logic [AW-1:0]           acc_ra;
  logic signed [ACC_W-1:0] acc_qx, acc_qy, acc_qz;

  logic signed [PW-1:0]    pa_x, pa_y, pa_z, pb_x, pb_y, pb_z, pc_x, pc_y, pc_z;
  logic signed [EW-1:0]    mul_a, mul_b;
  logic [2:0]              fold_sel;
  logic [ADDR_MAX_W-1:0]   corner;
  logic                    norm_start;
  logic                    norm_done;
  logic [UNIT_W-1:0]       norm_x, norm_y, norm_z;
  logic                    out_fire;

  function automatic logic signed [ACC_W-1:0] sat_add(
    input logic signed [ACC_W-1:0] a,
    input logic signed [FW-1:0]    b
  );
    logic signed [ACC_W:0] s;
    s = (ACC_W+1)'(a) + (ACC_W+1)'(b);
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? ACC_MIN : ACC_MAX;
    end
    return s[ACC_W-1:0];
  endfunction

  assign pa_x = pa[PW-1:0];
  assign pa_y = pa[2*PW-1:PW];
  assign pa_z = pa[3*PW-1:2*PW];
  assign pb_x = pb[PW-1:0];
  assign pb_y = pb[2*PW-1:PW];
  assign pb_z = pb[3*PW-1:2*PW];
  assign pc_x = pos_q[PW-1:0];
  assign pc_y = pos_q[2*PW-1:PW];
  assign pc_z = pos_q[3*PW-1:2*PW];

  always_comb begin
    pop      = (state == S_IDLE) && !empty;
    out_fire = (state == S_OUT) && (!result_valid || result_ready);
    fold_sel = mcnt - 3'd1;
    case (cj)
      2'd0:    corner = cur.ca;
      2'd1:    corner = cur.cb;
      default: corner = cur.cc;
    endcase
    case (mcnt)
      3'd0: begin
        mul_a = e1y;
        mul_b = e2z;
      end
      3'd1: begin
        mul_a = e1z;
        mul_b = e2y;
      end
      3'd2: begin
        mul_a = e1z;
        mul_b = e2x;
      end
      3'd3: begin
        mul_a = e1x;
        mul_b = e2z;
      end
      3'd4: begin
        mul_a = e1x;
        mul_b = e2y;
      end
      default: begin
        mul_a = e1y;
        mul_b = e2x;
      end
    endcase
    case (state)
      S_P0:    pos_ra = cur.ca[AW-1:0];
      S_P1:    pos_ra = cur.cb[AW-1:0];
      default: pos_ra = cur.cc[AW-1:0];
    endcase
    acc_ra = (state == S_RRD) ? cur.slot[AW-1:0] : corner[AW-1:0];
    pos_we = pop && (cmd.kind == KIND_LOAD) && cmd.slot_ok;
    pos_wa = cmd.slot[AW-1:0];
    pos_wd = {cmd.pz[PW-1:0], cmd.py[PW-1:0], cmd.px[PW-1:0]};
    if (state == S_AWR) begin
      acc_we   = 1'b1;
      acc_wa   = corner[AW-1:0];
      acc_wd_x = sat_add(acc_qx, fx);
      acc_wd_y = sat_add(acc_qy, fy);
      acc_wd_z = sat_add(acc_qz, fz);
    end else begin
      acc_we   = pos_we;
      acc_wa   = cmd.slot[AW-1:0];
      acc_wd_x = ACC_W'(cmd.nx);
      acc_wd_y = ACC_W'(cmd.ny);
      acc_wd_z = ACC_W'(cmd.nz);
    end
    norm_start = (state == S_RSTART);
  end

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[pos_wa] <= pos_wd;
    end
    pos_q <= pos_mem[pos_ra];
  end

  always_ff @(posedge clk) begin
    if (acc_we) begin
      acc_x_mem[acc_wa] <= acc_wd_x;
      acc_y_mem[acc_wa] <= acc_wd_y;
      acc_z_mem[acc_wa] <= acc_wd_z;
    end
    acc_qx <= acc_x_mem[acc_ra];
    acc_qy <= acc_y_mem[acc_ra];
    acc_qz <= acc_z_mem[acc_ra];
  end

  vna_norm u_norm (
    .clk    (clk),
    .rst    (rst),
    .start  (norm_start),
    .vec_x  (acc_qx),
    .vec_y  (acc_qy),
    .vec_z  (acc_qz),
    .done   (norm_done),
    .unit_x (norm_x),
    .unit_y (norm_y),
    .unit_z (norm_z)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      bad          <= 1'b0;
      tri_seen     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (out_fire) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            cur <= cmd;
            unique case (cmd.kind)
              KIND_LOAD: begin
              end
              KIND_TRI: begin
                if (!bad) begin
                  if (cmd.tri_ok) begin
                    state <= S_P0;
                  end else begin
                    bad <= 1'b1;
                  end
                end
              end
              KIND_READ: begin
                res.unit_x <= '0;
                res.unit_y <= '0;
                res.unit_z <= '0;
                if (bad) begin
                  res.status <= STATUS_BAD_INDEX;
                  state      <= S_OUT;
                end else if (!tri_seen) begin
                  res.status <= STATUS_NO_TRIANGLE;
                  state      <= S_OUT;
                end else begin
                  res.status <= STATUS_OK;
                  state      <= cmd.slot_ok ? S_RRD : S_OUT;
                end
              end
              KIND_BEGIN: begin
                bad      <= 1'b0;
                tri_seen <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        S_P0: state <= S_P1;
        S_P1: begin
          pa    <= pos_q;
          state <= S_P2;
        end
        S_P2: begin
          pb    <= pos_q;
          state <= S_EDGE;
        end
        S_EDGE: begin
          e1x   <= EW'(pb_x) - EW'(pa_x);
          e1y   <= EW'(pb_y) - EW'(pa_y);
          e1z   <= EW'(pb_z) - EW'(pa_z);
          e2x   <= EW'(pc_x) - EW'(pa_x);
          e2y   <= EW'(pc_y) - EW'(pa_y);
          e2z   <= EW'(pc_z) - EW'(pa_z);
          mcnt  <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          if (mcnt != 3'd6) begin
            prod <= mul_a * mul_b;
          end
          if (mcnt != 3'd0) begin
            case (fold_sel)
              3'd0:    fx <= FW'(prod);
              3'd1:    fx <= fx - FW'(prod);
              3'd2:    fy <= FW'(prod);
              3'd3:    fy <= fy - FW'(prod);
              3'd4:    fz <= FW'(prod);
              default: fz <= fz - FW'(prod);
            endcase
          end
          if (mcnt == 3'd6) begin
            cj    <= '0;
            state <= S_ARD;
          end
          mcnt <= mcnt + 3'd1;
        end
        S_ARD: state <= S_AWR;
        S_AWR: begin
          if (cj == 2'd2) begin
            tri_seen <= 1'b1;
            state    <= S_IDLE;
          end else begin
            cj    <= cj + 2'd1;
            state <= S_ARD;
          end
        end
        S_RRD:    state <= S_RSTART;
        S_RSTART: state <= S_RWAIT;
        S_RWAIT: begin
          if (norm_done) begin
            res.unit_x <= norm_x;
            res.unit_y <= norm_y;
            res.unit_z <= norm_z;
            state      <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_fire) begin
            result <= res;
            state  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/vertex_normal_accumulator_top.sv =====
// Top level of the vertex normal accumulator.
//
// Channels: item (valid/ready, one item_t per beat), result (valid/ready,
// one result_t per beat, only for read items) and cfg (valid/ready, the
// vertex count; always ready, write only while the block is idle).
// The front end registers the vertex count, classifies each beat and
// queues it; the back end works one command at a time.
// Work per item in the back end: load and begin are handled in the idle
// state, as is a triangle with a bad index or under a sticky error; a good
// triangle makes three position reads, six products on one multiplier and
// three accumulator read-modify-writes. A read that reports an error or an
// out-of-range slot goes straight to the result; a read of a zero vector
// skips the normalizer steps; any other read runs the iterative normalizer:
// up to 29 alignment shifts, 32 square root steps and one division per lane.
// Reset clears the vertex count, the error and triangle marks, the queue
// and the result valid flag; the vertex memories are not cleared.
// A stalled receiver holds the result register; the queue keeps taking
// items until full, and the back end stops only on the next result.
`default_nettype none

module vertex_normal_accumulator_top #(
  parameter int MAX_VERTICES = vna_pkg::DEF_MAX_VERTICES,
  parameter int POS_BITS     = vna_pkg::DEF_POS_BITS
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              cfg_valid,
  output logic             cfg_ready,
  input  wire [10:0]       cfg_data,
  input  wire              item_valid,
  output logic             item_ready,
  input  vna_pkg::item_t   item,
  output logic             result_valid,
  input  wire              result_ready,
  output vna_pkg::result_t result
);
  import vna_pkg::*;

  localparam int QDEPTH = 4;

  cmd_t front_cmd;
  cmd_t back_cmd;
  logic push;
  logic pop;
  logic q_empty;
  logic q_full;

  vna_front #(
    .MAX_VERTICES (MAX_VERTICES),
    .POS_BITS     (POS_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .full       (q_full),
    .push       (push),
    .cmd        (front_cmd)
  );

  vna_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (front_cmd),
    .pop   (pop),
    .dout  (back_cmd),
    .empty (q_empty),
    .full  (q_full)
  );

  vna_back #(
    .MAX_VERTICES (MAX_VERTICES),
    .POS_BITS     (POS_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd          (back_cmd),
    .empty        (q_empty),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

`default_nettype wire
